// ===== hdl/hba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hba_pkg
// Shared constants, codes and types of the boot report to ASCII translator.
// ----------------------------------------------------------------------------
package hba_pkg;

	// layout table geometry
	localparam int TABLE_DEPTH = 128;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);

	// report geometry
	localparam int KEY_FIELDS    = 6;
	localparam int KEY_SLOTS_DEF = 6;
	localparam int USAGE_W       = 6;

	// character codes swept by the search
	localparam logic [ADDR_W-1:0] FIRST_CODE = ADDR_W'(32);
	localparam logic [ADDR_W-1:0] LAST_CODE  = ADDR_W'(TABLE_DEPTH - 1);

	// usages and modifier masks
	localparam logic [7:0] SPACE_USAGE    = 8'h2c;
	localparam logic [7:0] MOD_SHIFT_MASK = 8'h22;
	localparam logic [7:0] MOD_ALTGR_MASK = 8'h40;

	// item kinds
	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_MERGE,
		ST_EMIT
	} state_t;

	// per-report setup broadcast to every lane
	typedef struct packed {
		logic load;
		logic shift;
		logic altgr;
	} lane_ctl_t;

	// one table entry read during the sweep
	typedef struct packed {
		logic              vld;
		logic [ADDR_W-1:0] code;
		logic [7:0]        entry;
	} beat_t;

	// merge stage status
	typedef struct packed {
		logic active;
		logic done;
	} mrg_stat_t;

endpackage
`default_nettype wire

// ===== hdl/hba_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hba_table
// Layout table: 128 x 8 memory with per-entry valid bits, registered read.
// ----------------------------------------------------------------------------
module hba_table (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      we,
	input  wire logic [hba_pkg::ADDR_W-1:0] waddr,
	input  wire logic [7:0]                wdata,
	input  wire logic                      re,
	input  wire logic [hba_pkg::ADDR_W-1:0] raddr,
	output hba_pkg::beat_t                 beat
);

	logic [7:0]                     mem [hba_pkg::TABLE_DEPTH];
	logic [hba_pkg::TABLE_DEPTH-1:0] valid_q;
	logic [7:0]                     rdata_s1;
	logic                           rvalid_s1;
	logic                           re_s1;
	logic [hba_pkg::ADDR_W-1:0]     code_s1;

	// storage array
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_s1 <= mem[raddr];
	end

	// valid bits: an entry never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rvalid_s1 <= 1'b0;
			re_s1     <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rvalid_s1 <= valid_q[raddr];
			re_s1     <= re;
		end
	end

	always_ff @(posedge clk) begin
		code_s1 <= raddr;
	end

	assign beat.vld   = re_s1;
	assign beat.code  = code_s1;
	assign beat.entry = rvalid_s1 ? rdata_s1 : 8'h00;

endmodule
`default_nettype wire

// ===== hdl/hba_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hba_lane
// One key slot: holds a usage and keeps the lowest code whose entry matches.
// ----------------------------------------------------------------------------
module hba_lane (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire hba_pkg::lane_ctl_t        ctl,
	input  wire logic [7:0]                key,
	input  wire hba_pkg::beat_t            beat,
	output logic                           found,
	output logic [hba_pkg::ADDR_W-1:0]     code
);

	logic [7:0]                 key_q;
	logic                       shift_q;
	logic                       altgr_q;
	logic                       found_q;
	logic [hba_pkg::ADDR_W-1:0] code_q;
	logic                       hit;

	// exact match on usage and both flags; usages of 64 and up never match
	assign hit = (key_q != 8'h00) && (key_q[7:hba_pkg::USAGE_W] == '0) &&
		(beat.entry == {shift_q, altgr_q, key_q[hba_pkg::USAGE_W-1:0]});

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			key_q   <= key;
			shift_q <= ctl.shift;
			altgr_q <= ctl.altgr;
		end
	end

	// space without AltGr resolves at once; otherwise first hit of the sweep wins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			code_q  <= hba_pkg::FIRST_CODE;
		end else if (ctl.load) begin
			found_q <= (key == hba_pkg::SPACE_USAGE) && !ctl.altgr;
			code_q  <= hba_pkg::FIRST_CODE;
		end else if (beat.vld && !found_q && hit) begin
			found_q <= 1'b1;
			code_q  <= beat.code;
		end
	end

	assign found = found_q;
	assign code  = code_q;

endmodule
`default_nettype wire

// ===== hdl/hba_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hba_merge
// Merges lane results: emits found characters in key order, one word a cycle.
// ----------------------------------------------------------------------------
module hba_merge #(
	parameter int LANES = hba_pkg::KEY_SLOTS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      load,
	input  wire logic [LANES-1:0]          found,
	input  wire logic [hba_pkg::ADDR_W-1:0] codes [LANES],
	input  wire logic [2:0]                limit,
	output hba_pkg::mrg_stat_t             stat,
	output logic                           strobe,
	output logic                           has_char,
	output logic [hba_pkg::ADDR_W-1:0]     char_code,
	output logic [2:0]                     position,
	output logic                           last
);

	localparam int SEL_W = (LANES > 1) ? $clog2(LANES) : 1;

	logic [LANES-1:0]           pend_q;
	logic [2:0]                 cnt_q;
	logic                       act_q;
	logic [SEL_W-1:0]           sel;
	logic [LANES-1:0]           rem;
	logic                       empty;
	logic                       last_c;
	logic                       strobe_q;
	logic                       has_char_q;
	logic [hba_pkg::ADDR_W-1:0] char_code_q;
	logic [2:0]                 position_q;
	logic                       last_q;

	// lowest pending lane
	always_comb begin
		sel = '0;
		for (int i = LANES - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				sel = SEL_W'(i);
			end
		end
	end

	assign rem    = pend_q & ~(LANES'(1) << sel);
	assign empty  = (pend_q == '0) || (limit == 3'd0);
	assign last_c = empty || (rem == '0) || ((cnt_q + 3'd1) == limit);

	// pending mask and character count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			cnt_q  <= 3'd0;
			act_q  <= 1'b0;
		end else if (load) begin
			pend_q <= found;
			cnt_q  <= 3'd0;
			act_q  <= 1'b1;
		end else if (act_q) begin
			pend_q <= rem;
			cnt_q  <= cnt_q + 3'd1;
			if (last_c) begin
				act_q <= 1'b0;
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= act_q;
		end
	end

	always_ff @(posedge clk) begin
		has_char_q  <= !empty;
		char_code_q <= empty ? '0 : codes[sel];
		position_q  <= empty ? 3'd0 : cnt_q;
		last_q      <= last_c;
	end

	assign stat.active = act_q;
	assign stat.done   = act_q && last_c;
	assign strobe      = strobe_q;
	assign has_char    = has_char_q;
	assign char_code   = char_code_q;
	assign position    = position_q;
	assign last        = last_q;

endmodule
`default_nettype wire

// ===== hdl/hid_boot_report_to_ascii.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hid_boot_report_to_ascii
// Translates HID boot keyboard reports to ASCII through a loadable layout table.
//
//   channel  | handshake      | payload
//   ---------+----------------+------------------------------------------------
//   input    | start / busy   | kind, entry_index, entry_value, modifier_bits,
//            |                | key_a..key_f, room
//   result   | strobe         | has_char, char_code, position, last
//
// A load word writes one table entry in its accept cycle; the next word may
// follow in the next cycle. A report reads the table once, codes 32 to 127,
// one entry a cycle, with all key lanes comparing the same entry in parallel:
// busy stays high in sweep, drain, merge and emit; a report has 1 to 6 results.
// Reset clears the table through per-entry valid bits at once, no sweep.
// Results come one per cycle and cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module hid_boot_report_to_ascii #(
	parameter int KEY_SLOTS = hba_pkg::KEY_SLOTS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic                      kind,
	input  wire logic [6:0]                entry_index,
	input  wire logic [7:0]                entry_value,
	input  wire logic [7:0]                modifier_bits,
	input  wire logic [7:0]                key_a,
	input  wire logic [7:0]                key_b,
	input  wire logic [7:0]                key_c,
	input  wire logic [7:0]                key_d,
	input  wire logic [7:0]                key_e,
	input  wire logic [7:0]                key_f,
	input  wire logic [2:0]                room,
	output logic                           strobe,
	output logic                           has_char,
	output logic [6:0]                     char_code,
	output logic [2:0]                     position,
	output logic                           last
);

	localparam int LANES = (KEY_SLOTS < hba_pkg::KEY_FIELDS) ? KEY_SLOTS :
		hba_pkg::KEY_FIELDS;

	hba_pkg::state_t            state_q;
	hba_pkg::state_t            state_d;
	logic [hba_pkg::ADDR_W-1:0] addr_q;
	logic [2:0]                 limit_q;
	logic                       accept;
	logic                       acc_load;
	logic                       acc_report;
	logic                       tbl_re;
	logic                       mrg_load;
	hba_pkg::lane_ctl_t         lane_ctl;
	hba_pkg::beat_t             beat;
	hba_pkg::mrg_stat_t         mrg_stat;
	logic [7:0]                 keys [hba_pkg::KEY_FIELDS];
	logic [LANES-1:0]           found;
	logic [hba_pkg::ADDR_W-1:0] codes [LANES];

	assign accept     = start && !busy;
	assign acc_load   = accept && (kind == hba_pkg::KIND_LOAD);
	assign acc_report = accept && (kind == hba_pkg::KIND_REPORT);

	assign keys[0] = key_a;
	assign keys[1] = key_b;
	assign keys[2] = key_c;
	assign keys[3] = key_d;
	assign keys[4] = key_e;
	assign keys[5] = key_f;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			hba_pkg::ST_IDLE: begin
				if (acc_report) begin
					state_d = hba_pkg::ST_SWEEP;
				end
			end
			hba_pkg::ST_SWEEP: begin
				if (addr_q == hba_pkg::LAST_CODE) begin
					state_d = hba_pkg::ST_DRAIN;
				end
			end
			hba_pkg::ST_DRAIN: state_d = hba_pkg::ST_MERGE;
			hba_pkg::ST_MERGE: state_d = hba_pkg::ST_EMIT;
			hba_pkg::ST_EMIT: begin
				if (mrg_stat.done) begin
					state_d = hba_pkg::ST_IDLE;
				end
			end
			default: state_d = hba_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		busy     = 1'b1;
		tbl_re   = 1'b0;
		mrg_load = 1'b0;
		case (state_q)
			hba_pkg::ST_IDLE:  busy     = 1'b0;
			hba_pkg::ST_SWEEP: tbl_re   = 1'b1;
			hba_pkg::ST_DRAIN: tbl_re   = 1'b0;
			hba_pkg::ST_MERGE: mrg_load = 1'b1;
			hba_pkg::ST_EMIT:  busy     = 1'b1;
			default:           busy     = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hba_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sweep address and report limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= hba_pkg::FIRST_CODE;
		end else if (acc_report) begin
			addr_q <= hba_pkg::FIRST_CODE;
		end else if (tbl_re && (addr_q != hba_pkg::LAST_CODE)) begin
			addr_q <= addr_q + hba_pkg::ADDR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (acc_report) begin
			limit_q <= (room == 3'd0) ? 3'd0 : room - 3'd1;
		end
	end

	// report setup broadcast to the lanes
	assign lane_ctl.load  = acc_report;
	assign lane_ctl.shift = (modifier_bits & hba_pkg::MOD_SHIFT_MASK) != 8'h00;
	assign lane_ctl.altgr = (modifier_bits & hba_pkg::MOD_ALTGR_MASK) != 8'h00;

	hba_table u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (acc_load),
		.waddr (entry_index),
		.wdata (entry_value),
		.re    (tbl_re),
		.raddr (addr_q),
		.beat  (beat)
	);

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		hba_lane u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (lane_ctl),
			.key   (keys[g]),
			.beat  (beat),
			.found (found[g]),
			.code  (codes[g])
		);
	end

	hba_merge #(
		.LANES(LANES)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (mrg_load),
		.found    (found),
		.codes    (codes),
		.limit    (limit_q),
		.stat     (mrg_stat),
		.strobe   (strobe),
		.has_char (has_char),
		.char_code(char_code),
		.position (position),
		.last     (last)
	);

	// a result word only follows a cycle of the emit state
	a_strobe_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q == hba_pkg::ST_EMIT))
		else $error("result word outside emit");

	// an empty result is always the only one of its report
	a_empty_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !has_char) |-> (last && (position == 3'd0) && (char_code == '0)))
		else $error("empty result not alone");

	// an accepted report keeps the block busy
	a_report_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc_report |=> (busy && (state_q == hba_pkg::ST_SWEEP)))
		else $error("report accepted without sweep");

	// sweep addresses stay within the printable range
	a_sweep_range: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_re |-> (addr_q >= hba_pkg::FIRST_CODE))
		else $error("sweep address below first code");

	// character positions never pass the lane count
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (position < 3'(LANES)))
		else $error("position out of range");

	// the merge stage runs exactly while in the emit state
	a_merge_active: assert property (@(posedge clk) disable iff (!arst_n)
		mrg_stat.active == (state_q == hba_pkg::ST_EMIT))
		else $error("merge activity out of step with emit");

endmodule
`default_nettype wire

// ===== verif/hba_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hba_tb_pkg
// Word type and character scoreboard for the boot report translator bench.
// The scoreboard keeps its own layout table, turns each accepted word into
// the characters it should produce and checks the strobed results in order.
// ----------------------------------------------------------------------------
package hba_tb_pkg;
	import hba_pkg::*;

	// layout entry flag bits
	localparam logic [7:0] ENT_SHIFT = 8'h80;
	localparam logic [7:0] ENT_ALTGR = 8'h40;

	// one input word, keys[0] is key_a
	typedef struct packed {
		logic            kind;
		logic [6:0]      entry_index;
		logic [7:0]      entry_value;
		logic [7:0]      modifier_bits;
		logic [5:0][7:0] keys;
		logic [2:0]      room;
	} hba_word_t;

	// one result word
	typedef struct packed {
		logic       has_char;
		logic [6:0] char_code;
		logic [2:0] position;
		logic       last;
	} char_out_t;

	class char_scoreboard;
		logic [7:0] layout [TABLE_DEPTH];
		char_out_t  expected_chars [$];
		int         errors;

		function new();
			foreach (layout[i]) layout[i] = 8'h00;
			errors = 0;
		endfunction

		// character for one key, 0 when the key yields nothing
		function logic [6:0] key_to_char(logic shift, logic altgr, logic [7:0] usage);
			logic [7:0] e;
			if (usage == 8'h00) return 7'd0;
			if (usage == SPACE_USAGE && !altgr) return FIRST_CODE;
			// lowest code wins
			for (int c = int'(FIRST_CODE); c < TABLE_DEPTH; c++) begin
				e = layout[c];
				if (e != 8'h00 && {2'b00, e[5:0]} == usage &&
				    ((e & ENT_SHIFT) != 8'h00) == shift &&
				    ((e & ENT_ALTGR) != 8'h00) == altgr)
					return 7'(c);
			end
			return 7'd0;
		endfunction

		// accepted input word: table write or report translation
		function void note_word(hba_word_t w);
			logic       shift;
			logic       altgr;
			logic [6:0] c;
			logic [6:0] found [KEY_FIELDS];
			int         limit;
			int         count;
			char_out_t  r;
			if (w.kind == KIND_LOAD) begin
				layout[w.entry_index] = w.entry_value;
				return;
			end
			shift = (w.modifier_bits & MOD_SHIFT_MASK) != 8'h00;
			altgr = (w.modifier_bits & MOD_ALTGR_MASK) != 8'h00;
			limit = (w.room == 3'd0) ? 0 : int'(w.room) - 1;
			count = 0;
			for (int i = 0; i < KEY_FIELDS && i < KEY_SLOTS_DEF; i++) begin
				c = key_to_char(shift, altgr, w.keys[i]);
				if (c == 7'd0) continue;
				if (count >= limit) break;
				found[count] = c;
				count++;
			end
			// nothing emitted: one empty word closes the report
			if (count == 0) begin
				r = '{has_char: 1'b0, char_code: 7'd0, position: 3'd0, last: 1'b1};
				expected_chars.push_back(r);
			end
			for (int i = 0; i < count; i++) begin
				r.has_char  = 1'b1;
				r.char_code = found[i];
				r.position  = 3'(i);
				r.last      = (i == count - 1);
				expected_chars.push_back(r);
			end
		endfunction

		function void compare(string field, logic [6:0] want, logic [6:0] got);
			if (want != got) begin
				$display("%0t: %s expected %0h actual %0h", $time, field, want, got);
				errors++;
			end
		endfunction

		// strobed result word against the oldest expectation
		function void check_result(char_out_t got);
			char_out_t want;
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected word: has_char %0d char %0h position %0d last %0d",
				         $time, got.has_char, got.char_code, got.position, got.last);
				errors++;
				return;
			end
			want = expected_chars.pop_front();
			compare("has_char", 7'(want.has_char), 7'(got.has_char));
			compare("char_code", want.char_code, got.char_code);
			compare("position", 7'(want.position), 7'(got.position));
			compare("last", 7'(want.last), 7'(got.last));
		endfunction

		function int pending();
			return expected_chars.size();
		endfunction
	endclass

endpackage

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Bench for the boot report to ASCII translator.
// Directed words cover spaces, flag matching, duplicate entries, wide usages
// and the capacity limit; random layout loads and reports follow, with the
// sender idling at different rates. Every strobed word is checked in order.
// ----------------------------------------------------------------------------
module tb;
	import hba_pkg::*;
	import hba_tb_pkg::*;

	localparam int WD_LIMIT     = 2000;
	localparam int DRAIN_CYCLES = 120;
	localparam int N_FILL       = 48;
	localparam int N_RANDOM     = 408;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic       kind;
	logic [6:0] entry_index;
	logic [7:0] entry_value;
	logic [7:0] modifier_bits;
	logic [7:0] key_a, key_b, key_c, key_d, key_e, key_f;
	logic [2:0] room;
	logic       strobe;
	logic       has_char;
	logic [6:0] char_code;
	logic [2:0] position;
	logic       last;

	char_scoreboard sb;
	int             idle_pct;
	int             stall_cycles;
	int             idle_by_phase [4] = '{0, 56, 0, 17};

	hid_boot_report_to_ascii DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.entry_index  (entry_index),
		.entry_value  (entry_value),
		.modifier_bits(modifier_bits),
		.key_a        (key_a),
		.key_b        (key_b),
		.key_c        (key_c),
		.key_d        (key_d),
		.key_e        (key_e),
		.key_f        (key_f),
		.room         (room),
		.strobe       (strobe),
		.has_char     (has_char),
		.char_code    (char_code),
		.position     (position),
		.last         (last)
	);

	always #1 clk = ~clk;

	// result monitor: the receiver takes every strobed word
	always @(posedge clk) begin
		if (arst_n && strobe === 1'b1)
			sb.check_result({has_char, char_code, position, last});
	end

	// watchdog on cycles with no word moving either way
	always @(posedge clk) begin
		if (!arst_n || (start && busy === 1'b0) || strobe === 1'b1)
			stall_cycles = 0;
		else
			stall_cycles = stall_cycles + 1;
		if (stall_cycles >= WD_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic hba_word_t mk_load(logic [6:0] idx, logic [7:0] val);
		hba_word_t w;
		w             = '0;
		w.kind        = KIND_LOAD;
		w.entry_index = idx;
		w.entry_value = val;
		return w;
	endfunction

	function automatic hba_word_t mk_report(logic [7:0] mods, logic [7:0] k0, logic [7:0] k1,
	                                        logic [7:0] k2, logic [7:0] k3, logic [7:0] k4,
	                                        logic [7:0] k5, logic [2:0] cap);
		hba_word_t w;
		w               = '0;
		w.kind          = KIND_REPORT;
		w.modifier_bits = mods;
		w.keys          = {k5, k4, k3, k2, k1, k0};
		w.room          = cap;
		return w;
	endfunction

	// {shift, altgr}, plain keys most often
	function automatic logic [1:0] rand_flags();
		int r;
		r = $urandom_range(99);
		if (r < 50) return 2'b00;
		if (r < 70) return 2'b10;
		if (r < 85) return 2'b01;
		return 2'b11;
	endfunction

	// entries crowd a few usages so duplicates are common
	function automatic logic [7:0] rand_entry();
		int r;
		r = $urandom_range(9);
		if (r == 0) return 8'h00;
		if (r < 4) return 8'($urandom_range(255));
		return {rand_flags(), 6'($urandom_range(11, 4))};
	endfunction

	// modifier byte with the given flags, other bits random
	function automatic logic [7:0] rand_mods(logic [1:0] f);
		logic [7:0] m;
		logic [7:0] sh;
		m  = 8'($urandom_range(255)) & ~(MOD_SHIFT_MASK | MOD_ALTGR_MASK);
		sh = MOD_SHIFT_MASK & 8'($urandom_range(255));
		if (sh == 8'h00) sh = MOD_SHIFT_MASK;
		if (f[1]) m = m | sh;
		if (f[0]) m = m | MOD_ALTGR_MASK;
		return m;
	endfunction

	// key usage, mostly one that the current table maps under these flags
	function automatic logic [7:0] pick_key(logic [1:0] f);
		int         r;
		int         c;
		logic [7:0] e;
		r = $urandom_range(99);
		if (r < 12) return 8'h00;
		if (r < 20) return SPACE_USAGE;
		if (r < 32) return 8'($urandom_range(255));
		repeat (16) begin
			c = $urandom_range(TABLE_DEPTH - 1, int'(FIRST_CODE));
			e = sb.layout[c];
			if (e != 8'h00 && ((e & ENT_SHIFT) != 8'h00) == f[1] &&
			    ((e & ENT_ALTGR) != 8'h00) == f[0])
				return {2'b00, e[5:0]};
		end
		return 8'($urandom_range(63));
	endfunction

	function automatic hba_word_t rand_load(logic [6:0] idx);
		hba_word_t w;
		// unused report fields carry noise
		w.kind          = KIND_LOAD;
		w.entry_index   = idx;
		w.entry_value   = rand_entry();
		w.modifier_bits = 8'($urandom_range(255));
		w.keys          = {16'($urandom_range(65535)), 32'($urandom())};
		w.room          = 3'($urandom_range(7));
		return w;
	endfunction

	function automatic hba_word_t rand_report();
		hba_word_t  w;
		logic [1:0] f;
		f               = rand_flags();
		w.kind          = KIND_REPORT;
		w.entry_index   = 7'($urandom_range(127));
		w.entry_value   = 8'($urandom_range(255));
		w.modifier_bits = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : rand_mods(f);
		for (int i = 0; i < KEY_FIELDS; i++)
			w.keys[i] = pick_key(f);
		w.room = ($urandom_range(99) < 20) ? 3'($urandom_range(7)) : 3'($urandom_range(7, 3));
		return w;
	endfunction

	// drive one word, optionally after an idle gap, and wait for accept
	task automatic send_word(hba_word_t w);
		int gap;
		if (idle_pct != 0 && int'($urandom_range(99)) < idle_pct) begin
			gap = ($urandom_range(3) == 0) ? $urandom_range(110, 1) : $urandom_range(6, 1);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start         <= 1'b1;
		kind          <= w.kind;
		entry_index   <= w.entry_index;
		entry_value   <= w.entry_value;
		modifier_bits <= w.modifier_bits;
		key_a         <= w.keys[0];
		key_b         <= w.keys[1];
		key_c         <= w.keys[2];
		key_d         <= w.keys[3];
		key_e         <= w.keys[4];
		key_f         <= w.keys[5];
		room          <= w.room;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_word(w);
	endtask

	initial begin
		sb            = new();
		idle_pct      = 0;
		clk           = 1'b0;
		arst_n        = 1'b0;
		start         = 1'b0;
		kind          = KIND_LOAD;
		entry_index   = 7'd0;
		entry_value   = 8'h00;
		modifier_bits = 8'h00;
		key_a         = 8'h00;
		key_b         = 8'h00;
		key_c         = 8'h00;
		key_d         = 8'h00;
		key_e         = 8'h00;
		key_f         = 8'h00;
		room          = 3'd0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: no keys, plain spaces, AltGr space finds nothing
		send_word(mk_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd7));
		send_word(mk_report(8'h00, SPACE_USAGE, 8'h00, SPACE_USAGE, 8'h00, 8'h00, 8'h00, 3'd7));
		send_word(mk_report(MOD_ALTGR_MASK, SPACE_USAGE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		                    3'd7));

		// small layout: plain, shifted, AltGr, both, duplicate, below range, usage zero
		send_word(mk_load(7'h61, 8'h04));
		send_word(mk_load(7'h41, ENT_SHIFT | 8'h04));
		send_word(mk_load(7'h40, ENT_ALTGR | 8'h14));
		send_word(mk_load(7'h20, ENT_ALTGR | SPACE_USAGE));
		send_word(mk_load(7'h7f, 8'hff));
		send_word(mk_load(7'h62, 8'h04));
		send_word(mk_load(7'h05, 8'h07));
		send_word(mk_load(7'h7e, ENT_SHIFT));

		// wide usages skipped, entries below the search range never hit
		send_word(mk_report(8'h00, 8'h04, 8'h00, SPACE_USAGE, 8'hff, 8'h44, 8'h07, 3'd7));
		// shift from either modifier bit, other modifier bits ignored
		send_word(mk_report(8'h02, 8'h04, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 3'd7));
		send_word(mk_report(8'hbd, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd7));
		// AltGr: table lookup, space goes through the table too
		send_word(mk_report(MOD_ALTGR_MASK, 8'h14, SPACE_USAGE, 8'h04, 8'h00, 8'h00, 8'h00,
		                    3'd7));
		send_word(mk_report(MOD_SHIFT_MASK | MOD_ALTGR_MASK, 8'h3f, SPACE_USAGE, 8'h00, 8'h00,
		                    8'h00, 8'h00, 3'd7));

		// capacity: full report, then room cuts it short down to nothing
		send_word(mk_report(8'h00, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 3'd7));
		send_word(mk_report(8'h00, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 3'd4));
		send_word(mk_report(8'h00, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 3'd2));
		send_word(mk_report(8'h00, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 3'd1));
		send_word(mk_report(8'h00, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 3'd0));

		// clearing the lowest match exposes the duplicate above it
		send_word(mk_load(7'h61, 8'h00));
		send_word(mk_report(8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd7));
		send_word(mk_report(8'hff, 8'hff, 8'h80, 8'hff, 8'h80, 8'hff, 8'h80, 3'd7));

		// random: fill the searched range, then mixed loads and reports
		for (int i = 0; i < N_RANDOM; i++) begin
			idle_pct = idle_by_phase[(i * 4) / N_RANDOM];
			if (i < N_FILL)
				send_word(rand_load(7'($urandom_range(TABLE_DEPTH - 1, int'(FIRST_CODE)))));
			else if ($urandom_range(99) < 40)
				send_word(rand_load(($urandom_range(99) < 85) ?
				                    7'($urandom_range(TABLE_DEPTH - 1, int'(FIRST_CODE))) :
				                    7'($urandom_range(127))));
			else
				send_word(rand_report());
		end
		start <= 1'b0;

		// drain, then allow for a stray word
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
